// ----- rtl/core/apf_pkg.sv -----
package apf_pkg;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DT_W      = 17;
  localparam int unsigned OPW       = 33;
  localparam int unsigned PRODW     = 66;
  localparam int unsigned SUMW      = 34;
  localparam int unsigned DIV_BITS  = 33;
  localparam int unsigned DCNT_W    = $clog2(DIV_BITS);

  localparam logic [CFG_W-1:0] GRAVITY_RESET = 31'd642908;
  localparam logic [CFG_W-1:0] MASS_RESET    = 31'd65536;
  localparam logic [DT_W-1:0]  TICK_RESET    = 17'd655;

  localparam logic signed [PRODW-1:0] TILT_MIN = 66'sd1048576;
  localparam logic signed [PRODW-1:0] MAX32_W  = 66'sd2147483647;
  localparam logic signed [PRODW-1:0] MIN32_W  = -66'sd2147483648;
  localparam logic signed [31:0]      MAX32    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]      MIN32    = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_KP, REG_REF_KD, REG_PID_KP, REG_PID_KI,
    REG_PID_KD, REG_GRAVITY, REG_MASS, REG_TICK
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_NONE, ST_ERR, ST_MUL_KPR, ST_MUL_KDR, ST_ACC_DIFF, ST_ACCR,
    ST_MUL_ACCR, ST_VEL, ST_MUL_VEL, ST_POS, ST_ERRS, ST_MUL_P,
    ST_MUL_I, ST_MUL_D, ST_MUL_T, ST_INTEG, ST_SUM, ST_R33_Y,
    ST_R33_Z, ST_R33, ST_DIV_SET, ST_DIV_STEP, ST_DIV_END,
    ST_MUL_THRUST, ST_THRUST
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load_in;
    logic  load_out;
  } apf_cmd_t;

  typedef struct packed {
    logic skip_div;
  } apf_status_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [PRODW-1:0] v);
    sat_t r;
    if (v > MAX32_W) begin
      r = '{hit: 1'b1, val: MAX32};
    end else if (v < MIN32_W) begin
      r = '{hit: 1'b1, val: MIN32};
    end else begin
      r = '{hit: 1'b0, val: v[31:0]};
    end
    return r;
  endfunction

  function automatic logic signed [PRODW-1:0] wide(input logic [31:0] x);
    return $signed({{(PRODW-32){x[31]}}, x});
  endfunction

endpackage

// ----- rtl/core/apf_in_if.sv -----
interface apf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_altitude;
  logic [31:0] measured_altitude;
  logic [31:0] measured_climb_rate;
  logic [15:0] quat_w;
  logic [15:0] quat_x;
  logic [15:0] quat_y;
  logic [15:0] quat_z;

  modport source (output valid, target_altitude, measured_altitude, measured_climb_rate,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, target_altitude, measured_altitude, measured_climb_rate,
                quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- rtl/core/apf_out_if.sv -----
interface apf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] accel_command;
  logic [31:0] thrust_command;
  logic [31:0] reference_altitude;
  logic [31:0] reference_climb_rate;
  logic        saturation_flag;

  modport source (output valid, accel_command, thrust_command, reference_altitude,
                  reference_climb_rate, saturation_flag, input ready);
  modport sink (input valid, accel_command, thrust_command, reference_altitude,
                reference_climb_rate, saturation_flag, output ready);
endinterface

// ----- rtl/core/apf_ctrl.sv -----
module apf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  apf_pkg::apf_status_t status,
  output apf_pkg::apf_cmd_t    cmd
);
  import apf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_DONE} state_t;

  state_t            state;
  step_t             step;
  logic [DCNT_W-1:0] div_cnt;

  assign in_ready     = (state == S_IDLE);
  assign cmd.load_in  = in_valid && in_ready;
  assign cmd.load_out = (state == S_DONE) && (!out_valid || out_ready);
  assign cmd.step     = (state == S_RUN) ? step :
                        (state == S_DIV) ? ST_DIV_STEP : ST_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_NONE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load_in) begin
            state <= S_RUN;
            step  <= ST_ERR;
          end
        end
        S_RUN: begin
          if (step == ST_DIV_SET) begin
            div_cnt <= '0;
            if (status.skip_div) begin
              step <= ST_DIV_END;
            end else begin
              state <= S_DIV;
            end
          end else if (step == ST_THRUST) begin
            state <= S_DONE;
          end else begin
            step <= step_t'(step + 5'd1);
          end
        end
        S_DIV: begin
          if (div_cnt == DCNT_W'(DIV_BITS - 1)) begin
            state <= S_RUN;
            step  <= ST_DIV_END;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt <= DCNT_W'(DIV_BITS - 1))
    else $error("divider ran past its last quotient bit");
  a_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (state == S_RUN && step == ST_ERR))
    else $error("accepted request did not start the sequence");
`endif
endmodule

// ----- rtl/core/apf_dpath.sv -----
module apf_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [apf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apf_pkg::CFG_W-1:0]    cfg_data,
  input  apf_pkg::apf_cmd_t            cmd,
  output apf_pkg::apf_status_t         status,
  input  logic [31:0]                  in_target,
  input  logic [31:0]                  in_alt,
  input  logic [31:0]                  in_rate,
  input  logic [15:0]                  in_qw,
  input  logic [15:0]                  in_qx,
  input  logic [15:0]                  in_qy,
  input  logic [15:0]                  in_qz,
  output logic [31:0]                  accel_command,
  output logic [31:0]                  thrust_command,
  output logic [31:0]                  reference_altitude,
  output logic [31:0]                  reference_climb_rate,
  output logic                         saturation_flag
);
  import apf_pkg::*;

  logic [CFG_W-1:0] ref_kp, ref_kd, pid_kp, pid_ki, pid_kd, gravity, mass;
  logic [DT_W-1:0]  tick;

  logic [31:0] tgt, alt, rate;
  logic [15:0] qw, qx, qy, qz;
  logic [31:0] pos, vel, integ;
  logic [31:0] er, accr, e, de, p, t, d, accel, thrust;
  logic signed [SUMW-1:0]  sum;
  logic signed [PRODW-1:0] acc, prod;
  logic signed [OPW-1:0]   opa, opb;
  logic        flag, tilt, ovf, neg;
  logic [31:0] dvs, rem;
  logic [DIV_BITS-1:0] dvd, quo;

  logic [SUMW-1:0] mag;
  logic [32:0]     trial;
  logic            ovf_now, tilt_now, div_hit;
  sat_t            s1, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_kp  <= '0;
      ref_kd  <= '0;
      pid_kp  <= '0;
      pid_ki  <= '0;
      pid_kd  <= '0;
      gravity <= GRAVITY_RESET;
      mass    <= MASS_RESET;
      tick    <= TICK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_KP:  ref_kp  <= cfg_data;
        REG_REF_KD:  ref_kd  <= cfg_data;
        REG_PID_KP:  pid_kp  <= cfg_data;
        REG_PID_KI:  pid_ki  <= cfg_data;
        REG_PID_KD:  pid_kd  <= cfg_data;
        REG_GRAVITY: gravity <= cfg_data;
        REG_MASS:    mass    <= cfg_data;
        REG_TICK:    tick    <= cfg_data[DT_W-1:0];
        default:     tick    <= tick;
      endcase
    end
  end

  // Shared multiplier operand selection; the product is registered every cycle.
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.step)
      ST_MUL_KPR:    begin opa = $signed({2'b0, ref_kp}); opb = $signed({er[31], er}); end
      ST_MUL_KDR:    begin opa = $signed({2'b0, ref_kd}); opb = $signed({vel[31], vel}); end
      ST_MUL_ACCR:   begin opa = $signed({accr[31], accr}); opb = $signed({16'b0, tick}); end
      ST_MUL_VEL:    begin opa = $signed({vel[31], vel}); opb = $signed({16'b0, tick}); end
      ST_MUL_P:      begin opa = $signed({2'b0, pid_kp}); opb = $signed({e[31], e}); end
      ST_MUL_I:      begin opa = $signed({2'b0, pid_ki}); opb = $signed({e[31], e}); end
      ST_MUL_D:      begin opa = $signed({2'b0, pid_kd}); opb = $signed({de[31], de}); end
      ST_MUL_T:      begin opa = $signed({t[31], t}); opb = $signed({16'b0, tick}); end
      ST_INTEG:      begin opa = $signed({{17{qw[15]}}, qw}); opb = opa; end
      ST_SUM:        begin opa = $signed({{17{qx[15]}}, qx}); opb = opa; end
      ST_R33_Y:      begin opa = $signed({{17{qy[15]}}, qy}); opb = opa; end
      ST_R33_Z:      begin opa = $signed({{17{qz[15]}}, qz}); opb = opa; end
      ST_MUL_THRUST: begin opa = $signed({2'b0, mass}); opb = $signed({accel[31], accel}); end
      default: ;
    endcase
  end

  always_comb begin
    mag      = sum[SUMW-1] ? SUMW'(-sum) : sum;
    tilt_now = (acc <= TILT_MIN);
    ovf_now  = ({3'b0, mag[SUMW-1:5]} >= acc[31:0]);
    trial    = {rem, dvd[DIV_BITS-1]};
    div_hit  = (cmd.step == ST_DIV_SET && tilt_now) ||
               (cmd.step == ST_DIV_END && !tilt && (ovf ||
                (neg && quo > 33'h0_8000_0000) || (!neg && quo > 33'h0_7FFF_FFFF)));
    s1       = '{hit: 1'b0, val: '0};
    s2       = '{hit: 1'b0, val: '0};
    case (cmd.step) inside
      ST_ERR:   s1 = sat32(wide(tgt) - wide(pos));
      ST_ACCR:  s1 = sat32(acc >>> 16);
      ST_VEL:   s1 = sat32(wide(vel) + (prod >>> 16));
      ST_POS:   s1 = sat32(wide(pos) + (prod >>> 16));
      ST_ERRS: begin
        s1 = sat32(wide(pos) - wide(alt));
        s2 = sat32(wide(vel) - wide(rate));
      end
      ST_MUL_I, ST_MUL_D, ST_MUL_T, ST_THRUST: s1 = sat32(prod >>> 16);
      ST_INTEG: s1 = sat32(wide(integ) + (prod >>> 16));
      default: ;
    endcase
  end

  assign status.skip_div = tilt_now || ovf_now;

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (rst) begin
      pos   <= '0;
      vel   <= '0;
      integ <= '0;
      flag  <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        flag <= 1'b0;
      end else if (div_hit) begin
        flag <= 1'b1;
      end else begin
        flag <= flag | s1.hit | s2.hit;
      end
      case (cmd.step)
        ST_POS:   pos   <= s1.val;
        ST_VEL:   vel   <= s1.val;
        ST_INTEG: integ <= s1.val;
        default: ;
      endcase
    end
    if (cmd.load_in) begin
      tgt  <= in_target;
      alt  <= in_alt;
      rate <= in_rate;
      qw   <= in_qw;
      qx   <= in_qx;
      qy   <= in_qy;
      qz   <= in_qz;
    end
    case (cmd.step) inside
      ST_ERR:      er   <= s1.val;
      ST_MUL_KDR:  acc  <= prod;
      ST_ACC_DIFF: acc  <= acc - prod;
      ST_ACCR:     accr <= s1.val;
      ST_ERRS: begin
        e  <= s1.val;
        de <= s2.val;
      end
      ST_MUL_I:    p <= s1.val;
      ST_MUL_D:    t <= s1.val;
      ST_MUL_T:    d <= s1.val;
      ST_SUM: begin
        sum <= $signed({3'b0, gravity}) + $signed({{2{p[31]}}, p}) +
               $signed({{2{integ[31]}}, integ}) + $signed({{2{d[31]}}, d});
        acc <= prod;
      end
      ST_R33_Y, ST_R33_Z: acc <= acc - prod;
      ST_R33:      acc <= acc + prod;
      ST_DIV_SET: begin
        // The dividend is |sum| << 28; its top bits seed the remainder.
        tilt <= tilt_now;
        ovf  <= ovf_now;
        neg  <= sum[SUMW-1];
        dvs  <= acc[31:0];
        rem  <= {3'b0, mag[SUMW-1:5]};
        dvd  <= {mag[4:0], 28'b0};
        quo  <= '0;
        if (tilt_now) begin
          accel <= (sum > 34'sd0) ? MAX32 : (sum < 34'sd0) ? MIN32 : 32'd0;
        end
      end
      ST_DIV_STEP: begin
        dvd <= {dvd[DIV_BITS-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= 32'(trial - {1'b0, dvs});
          quo <= {quo[DIV_BITS-2:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[DIV_BITS-2:0], 1'b0};
        end
      end
      ST_DIV_END: begin
        if (!tilt) begin
          if (ovf) begin
            accel <= neg ? MIN32 : MAX32;
          end else if (neg) begin
            accel <= (quo > 33'h0_8000_0000) ? MIN32 : 32'(-quo);
          end else begin
            accel <= (quo > 33'h0_7FFF_FFFF) ? MAX32 : quo[31:0];
          end
        end
      end
      ST_THRUST:   thrust <= s1.val;
      default: ;
    endcase
    if (cmd.load_out) begin
      accel_command        <= accel;
      thrust_command       <= thrust;
      reference_altitude   <= pos;
      reference_climb_rate <= vel;
      saturation_flag      <= flag;
    end
  end
endmodule

// ----- rtl/core/altitude_pid_with_reference_filter_unit.sv -----
// Channel  | Direction | Payload
// sample   | in        | target_altitude, measured_altitude, measured_climb_rate, quat_w..z
// result   | out       | accel_command, thrust_command, reference_altitude,
//          |           | reference_climb_rate, saturation_flag
// cfg      | in        | cfg_write, cfg_index, cfg_data (write only)
// One request runs from acceptance to the result register through the 24 controller
// steps around the shared 33x33 multiplier and the one-bit-per-cycle divider (33 steps).
// A small tilt or an overflowing quotient skips the divider.
// A new request is taken once the previous one has reached the result register,
// which may still be waiting to be taken. Reset is synchronous and clears the state.
module altitude_pid_with_reference_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [apf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apf_pkg::CFG_W-1:0]     cfg_data,
  apf_in_if.sink                        sample,
  apf_out_if.source                     result
);
  import apf_pkg::*;

  apf_cmd_t    cmd;
  apf_status_t status;

  apf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  apf_dpath u_dpath (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .cmd                  (cmd),
    .status               (status),
    .in_target            (sample.target_altitude),
    .in_alt               (sample.measured_altitude),
    .in_rate              (sample.measured_climb_rate),
    .in_qw                (sample.quat_w),
    .in_qx                (sample.quat_x),
    .in_qy                (sample.quat_y),
    .in_qz                (sample.quat_z),
    .accel_command        (result.accel_command),
    .thrust_command       (result.thrust_command),
    .reference_altitude   (result.reference_altitude),
    .reference_climb_rate (result.reference_climb_rate),
    .saturation_flag      (result.saturation_flag)
  );
endmodule
